/* src/assert_macros.svh */
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, held off during reset.
`define MSC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("membership table check failed");

// Implication checked in the following cycle, held off during reset.
`define MSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("membership table check failed");

`endif

/* src/msc_pkg.sv */
package msc_pkg;

    // Default list capacity
    localparam int MSC_CAPACITY = 16;

    // Field widths fixed by the request and result formats
    localparam int ID_W    = 15;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_INVALID = 3'd2,
        ST_DUP     = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_ABSENT  = 3'd5,
        ST_RANGE   = 3'd6
    } status_t;

    // Compare request broadcast to every cell on acceptance
    typedef struct packed {
        logic              load;
        logic              neg;
        logic [ID_W-1:0]   id;
        logic [SLOT_W-1:0] pos;
    } cmp_t;

    // Update broadcast to every cell on commit
    typedef struct packed {
        logic            shift;
        logic            append;
        logic [ID_W-1:0] id;
    } upd_t;

    // Search and read results rippled along the row of cells
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              rsel;
        logic [ID_W-1:0]   rdata;
    } chain_t;

endpackage

/* src/msc_cell.sv */
module msc_cell
    import msc_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CNT_W-1:0] count,
    input  cmp_t             cmp,
    input  upd_t             upd,
    input  logic [ID_W-1:0]  nbr_entry,
    output logic [ID_W-1:0]  entry,
    input  chain_t           chain_in,
    output chain_t           chain_out
);

    localparam logic [SLOT_W-1:0] SLOT = SLOT_W'(INDEX);

    logic [ID_W-1:0] entry_reg;
    logic            match_reg;
    logic            sel_reg;
    logic            live;
    logic            at_tail;
    logic            pos_hit;
    logic            hit_incl;

    // Slot occupancy and addressing relative to the current count
    assign live     = 32'(count) > INDEX;
    assign at_tail  = 32'(count) == INDEX;
    assign pos_hit  = 32'(cmp.pos) == INDEX;
    assign hit_incl = chain_in.hit | match_reg;

    // Latch the compare outcome when a request is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else if (cmp.load) begin
            match_reg <= !cmp.neg && live && (entry_reg == cmp.id);
            sel_reg   <= live && pos_hit;
        end
    end

    // Close the gap on remove, take the new member on append
    always_ff @(posedge aclk) begin
        if (upd.shift && hit_incl) begin
            entry_reg <= nbr_entry;
        end else if (upd.append && at_tail) begin
            entry_reg <= upd.id;
        end
    end

    // Pass the search and read results on to the next cell
    always_comb begin
        chain_out.hit   = hit_incl;
        chain_out.slot  = match_reg ? SLOT : chain_in.slot;
        chain_out.rsel  = chain_in.rsel | sel_reg;
        chain_out.rdata = sel_reg ? entry_reg : chain_in.rdata;
    end

    assign entry = entry_reg;

endmodule

/* src/membership_set_table.sv */
// Packed membership list of CAPACITY identifiers held in a row of cells, one
// entry per cell. Each request is add, remove, query or read by position and
// gives exactly one result with status, search hit and slot, read value and
// the count after the operation. In the cycle a request is accepted every
// cell compares its entry against the identifier and the read position;
// then, in S_COMMIT once the output register is free, the hit, slot and read
// value ripple down the row of cells, the status is decided, and the cells
// append or shift down. s_tready is low in S_COMMIT, which lasts while the
// previous result still sits unclaimed in the output register. The list
// needs no clearing after reset; slots at or above the count are never read.
module membership_set_table
    import msc_pkg::*;
#(
    parameter int CAPACITY = MSC_CAPACITY
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [1:0] mode, [17:2] user_id, [21:18] position, [23:22] zero
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [2:0] status, [3] is_member, [7:4] found_position,
    // [22:8] member_read, [27:23] member_count, [31:28] zero
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_COMMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    mode_t               mode_reg, mode_next;
    logic                neg_reg, neg_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic             accept;
    logic             out_free;
    logic             commit;
    logic             found;
    logic             do_add;
    logic             do_remove;
    status_t          status;
    logic [CNT_W-1:0] count_after;
    logic [ID_W-1:0]  readv;
    cmp_t             cmp;
    upd_t             upd;
    chain_t           chain [CAPACITY+1];
    logic [ID_W-1:0]  ent_w [CAPACITY+1];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (state_reg == S_COMMIT) && out_free;

    // Broadcast the incoming request to the cells
    assign cmp.load = accept;
    assign cmp.neg  = s_tdata[17];
    assign cmp.id   = s_tdata[16:2];
    assign cmp.pos  = s_tdata[21:18];

    assign upd.shift  = commit && do_remove;
    assign upd.append = commit && do_add;
    assign upd.id     = id_reg;

    // Row of cells, results rippling from slot 0 upward
    assign chain[0]        = '0;
    assign ent_w[CAPACITY] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        msc_cell #(
            .INDEX (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .count     (count_reg),
            .cmp       (cmp),
            .upd       (upd),
            .nbr_entry (ent_w[g+1]),
            .entry     (ent_w[g]),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1])
        );
    end

    // Decide the status and the new count from the rippled results
    always_comb begin
        found       = (mode_reg != MODE_READ) && chain[CAPACITY].hit;
        status      = ST_OK;
        count_after = count_reg;
        do_add      = 1'b0;
        do_remove   = 1'b0;
        readv       = '0;
        unique case (mode_reg)
            MODE_ADD: begin
                if (32'(count_reg) >= CAPACITY) begin
                    status = ST_FULL;
                end else if (neg_reg) begin
                    status = ST_INVALID;
                end else if (found) begin
                    status = ST_DUP;
                end else begin
                    do_add      = 1'b1;
                    count_after = count_reg + CNT_W'(1);
                end
            end
            MODE_REMOVE: begin
                if (count_reg == '0) begin
                    status = ST_EMPTY;
                end else if (neg_reg) begin
                    status = ST_INVALID;
                end else if (!found) begin
                    status = ST_ABSENT;
                end else begin
                    do_remove   = 1'b1;
                    count_after = count_reg - CNT_W'(1);
                end
            end
            MODE_QUERY: begin
                if (neg_reg) begin
                    status = ST_INVALID;
                end else if (!found) begin
                    status = ST_ABSENT;
                end
            end
            MODE_READ: begin
                if (chain[CAPACITY].rsel) begin
                    readv = chain[CAPACITY].rdata;
                end else begin
                    status = ST_RANGE;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    // Next state, request hold and output register
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        mode_next     = mode_reg;
        neg_next      = neg_reg;
        id_next       = id_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    mode_next  = mode_t'(s_tdata[1:0]);
                    neg_next   = s_tdata[17];
                    id_next    = s_tdata[16:2];
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    count_next    = count_after;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, COUNT_W'(count_after), readv,
                                     (found ? chain[CAPACITY].slot : SLOT_W'(0)),
                                     found, status};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        mode_reg    <= mode_next;
        neg_reg     <= neg_next;
        id_reg      <= id_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* src/msc_checker.sv */
`include "assert_macros.svh"

module msc_checker
    import msc_pkg::*;
#(
    parameter int CAPACITY = MSC_CAPACITY
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    logic [2:0]         m_status;
    logic [COUNT_W-1:0] m_count;
    logic               hit_ok;

    // Pick the result fields out of the data word
    assign m_status = m_tdata[2:0];
    assign m_count  = m_tdata[27:23];
    assign hit_ok   = (m_status == ST_OK) || (m_status == ST_DUP) || (m_status == ST_FULL);

    // A stalled result holds
    `MSC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // An accepted request blocks the next one for its commit cycle
    `MSC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // The count never passes the capacity
    `MSC_ASSERT_IMPL(a_count_bound, m_tvalid, (CAPACITY > 31) || (m_count <= CAPACITY))

    // A search hit only goes with ok, duplicate or full
    `MSC_ASSERT_IMPL(a_hit_status, m_tvalid && m_tdata[3], hit_ok)

    // An out of range read returns nothing
    `MSC_ASSERT_IMPL(a_range_empty, m_tvalid && (m_status == ST_RANGE), (m_tdata[22:8] == '0) && !m_tdata[3])

endmodule

bind membership_set_table msc_checker #(.CAPACITY(CAPACITY)) u_msc_checker (.*);
